// ===== sv/sawtq_pkg.sv =====
`timescale 1ns / 1ps

package sawtq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int NODE_COUNT  = 16;

  localparam int QIDX_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_CFM  = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFM_SUCCESS  = 2'd0,
    CFM_NO_REACH = 2'd1,
    CFM_BUSY     = 2'd2
  } cfm_e;

  typedef enum logic {
    OUT_SEND    = 1'b0,
    OUT_CONFIRM = 1'b1
  } out_kind_e;

  typedef enum logic [1:0] {
    EMIT_NONE    = 2'd0,
    EMIT_SEND    = 2'd1,
    EMIT_CONFIRM = 2'd2
  } emit_e;

  // One packet descriptor as held in the ring.
  typedef struct packed {
    logic [7:0]  service_type;
    logic [15:0] packet_number;
    logic [3:0]  priority_lvl;
    logic [15:0] dest_addr;
    logic [9:0]  length;
    logic [15:0] payload_handle;
  } desc_t;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [3:0]  target_node;
    logic [15:0] dest_addr;
    logic [3:0]  priority_lvl;
    logic [7:0]  service_type;
    logic [15:0] packet_number;
    logic [9:0]  length;
    logic [15:0] payload_handle;
    cfm_e        confirm_code;
    logic        enqueue_failed;
    logic        last;
  } res_t;

  typedef struct packed {
    logic  capture;
    logic  enqueue;
    logic  read_head;
    emit_e emit;
    cfm_e  code;
    logic  last;
    logic  use_failed;
    logic  pop;
    logic  start_timer;
    logic  stop_timer;
    logic  tick_dec;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e in_kind;
    kind_e kind;
    logic  waiting;
    logic  full;
    logic  count_one;
    logic  count_nonzero;
    logic  cfm_ok;
    logic  tick_expire;
    logic  out_free;
  } dp_status_t;

endpackage

// ===== sv/sawtq_in_if.sv =====
`timescale 1ns / 1ps

interface sawtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  req_service_type;
  logic [15:0] req_packet_number;
  logic [3:0]  req_priority;
  logic [15:0] req_dest_addr;
  logic [9:0]  req_length;
  logic [15:0] req_payload_handle;
  logic [1:0]  cfm_result;
  logic [15:0] cfm_packet_number;

  modport source (
    output valid, kind, req_service_type, req_packet_number, req_priority,
    output req_dest_addr, req_length, req_payload_handle, cfm_result,
    output cfm_packet_number,
    input  ready
  );

  modport sink (
    input  valid, kind, req_service_type, req_packet_number, req_priority,
    input  req_dest_addr, req_length, req_payload_handle, cfm_result,
    input  cfm_packet_number,
    output ready
  );
endinterface

// ===== sv/sawtq_out_if.sv =====
`timescale 1ns / 1ps

interface sawtq_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [3:0]  target_node;
  logic [15:0] out_dest_addr;
  logic [3:0]  out_priority;
  logic [7:0]  out_service_type;
  logic [15:0] out_packet_number;
  logic [9:0]  out_length;
  logic [15:0] out_payload_handle;
  logic [1:0]  confirm_code;
  logic        enqueue_failed;
  logic        last;

  modport source (
    output valid, out_kind, target_node, out_dest_addr, out_priority,
    output out_service_type, out_packet_number, out_length, out_payload_handle,
    output confirm_code, enqueue_failed, last,
    input  ready
  );

  modport sink (
    input  valid, out_kind, target_node, out_dest_addr, out_priority,
    input  out_service_type, out_packet_number, out_length, out_payload_handle,
    input  confirm_code, enqueue_failed, last,
    output ready
  );
endinterface

// ===== sv/sawtq_ram.sv =====
`timescale 1ns / 1ps

module sawtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sawtq_dp.sv =====
`timescale 1ns / 1ps

module sawtq_dp import sawtq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  input  logic [1:0]            in_kind_i,
  input  desc_t                 in_desc_i,
  input  logic [1:0]            in_cfm_result_i,
  input  logic [15:0]           in_cfm_pn_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output res_t                  out_res_o
);

  localparam logic [QIDX_W-1:0] LAST_IDX = QIDX_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  logic [3:0]        local_node_q;
  logic [15:0]       timeout_q;
  logic [QIDX_W-1:0] head_q, tail_q;
  logic [QCNT_W-1:0] count_q;
  logic              waiting_q;
  logic [15:0]       ticks_q;
  logic              out_valid_q;
  res_t              res_q;

  kind_e             kind_q;
  desc_t             req_q;
  logic [1:0]        cfm_result_q;
  logic [15:0]       cfm_pn_q;
  logic              failed_q;

  desc_t             head_desc;
  res_t              res_d;
  logic              full;
  logic              out_free;
  logic [15:0]       timer_load;

  sawtq_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enqueue),
    .waddr_i (tail_q),
    .wdata_i (in_desc_i),
    .re_i    (cmd_i.read_head),
    .raddr_i (head_q),
    .rdata_o (head_desc)
  );

  assign full       = (count_q == FULL_CNT);
  assign out_free   = !out_valid_q || out_ready_i;
  // A zero timeout register behaves as one tick.
  assign timer_load = (timeout_q == 16'd0) ? 16'd1 : timeout_q;

  always_comb begin
    res_d = '0;
    if (cmd_i.emit == EMIT_SEND) begin
      res_d.out_kind       = OUT_SEND;
      res_d.target_node    = (head_desc.dest_addr < 16'(NODE_COUNT)) ?
                             head_desc.dest_addr[3:0] : local_node_q;
      res_d.dest_addr      = head_desc.dest_addr;
      res_d.priority_lvl   = head_desc.priority_lvl;
      res_d.service_type   = head_desc.service_type;
      res_d.packet_number  = head_desc.packet_number;
      res_d.length         = head_desc.length;
      res_d.payload_handle = head_desc.payload_handle;
      res_d.confirm_code   = CFM_SUCCESS;
      res_d.enqueue_failed = cmd_i.use_failed & failed_q;
    end else begin
      res_d.out_kind     = OUT_CONFIRM;
      res_d.confirm_code = cmd_i.code;
      // A busy confirm answers the rejected request, the others the head entry.
      if (cmd_i.code == CFM_BUSY) begin
        res_d.priority_lvl  = req_q.priority_lvl;
        res_d.packet_number = req_q.packet_number;
      end else begin
        res_d.priority_lvl  = head_desc.priority_lvl;
        res_d.packet_number = head_desc.packet_number;
      end
    end
    res_d.last = cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_node_q <= '0;
      timeout_q    <= TIMEOUT_RESET;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      waiting_q    <= 1'b0;
      ticks_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LOCAL_NODE) begin
          local_node_q <= cfg_data_i[3:0];
        end else if (cfg_idx_i == CFG_TIMEOUT) begin
          timeout_q <= cfg_data_i[15:0];
        end
      end
      if (cmd_i.enqueue) begin
        tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end else if (cmd_i.pop) begin
        head_q  <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.start_timer) begin
        waiting_q <= 1'b1;
        ticks_q   <= timer_load;
      end else if (cmd_i.stop_timer) begin
        waiting_q <= 1'b0;
        ticks_q   <= '0;
      end else if (cmd_i.tick_dec) begin
        ticks_q <= ticks_q - 1'b1;
      end
      if (cmd_i.emit != EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q       <= kind_e'(in_kind_i);
      req_q        <= in_desc_i;
      cfm_result_q <= in_cfm_result_i;
      cfm_pn_q     <= in_cfm_pn_i;
      failed_q     <= full;
    end
    if (cmd_i.emit != EMIT_NONE) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    status_o               = '0;
    status_o.in_kind       = kind_e'(in_kind_i);
    status_o.kind          = kind_q;
    status_o.waiting       = waiting_q;
    status_o.full          = full;
    status_o.count_one     = (count_q == QCNT_W'(1));
    status_o.count_nonzero = (count_q != '0);
    status_o.cfm_ok        = (cfm_result_q == CFM_SUCCESS) &&
                             (cfm_pn_q == head_desc.packet_number);
    status_o.tick_expire   = (ticks_q <= 16'd1);
    status_o.out_free      = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== sv/sawtq_ctrl.sv =====
`timescale 1ns / 1ps

module sawtq_ctrl import sawtq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_READ_NEXT,
    S_SEND_NEXT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit = EMIT_NONE;
    cmd_o.code = CFM_SUCCESS;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.capture = 1'b1;
          cmd_o.enqueue = (status_i.in_kind == KIND_REQ) && !status_i.waiting &&
                          !status_i.full;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read_head = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        case (status_i.kind)
          KIND_REQ: begin
            if (status_i.out_free) begin
              cmd_o.emit = status_i.waiting ? EMIT_CONFIRM : EMIT_SEND;
              cmd_o.code = status_i.waiting ? CFM_BUSY : CFM_SUCCESS;
              cmd_o.last = 1'b1;
              cmd_o.use_failed  = !status_i.waiting;
              cmd_o.start_timer = !status_i.waiting;
              state_d = S_IDLE;
            end
          end
          KIND_CFM: begin
            if (status_i.waiting && status_i.count_nonzero && status_i.cfm_ok) begin
              if (status_i.out_free) begin
                cmd_o.emit = EMIT_CONFIRM;
                cmd_o.code = CFM_SUCCESS;
                cmd_o.last = status_i.count_one;
                cmd_o.pop  = 1'b1;
                if (status_i.count_one) begin
                  cmd_o.stop_timer = 1'b1;
                  state_d = S_IDLE;
                end else begin
                  state_d = S_READ_NEXT;
                end
              end
            end else begin
              state_d = S_IDLE;
            end
          end
          KIND_TICK: begin
            if (status_i.waiting && status_i.tick_expire) begin
              if (status_i.out_free) begin
                cmd_o.emit = EMIT_CONFIRM;
                cmd_o.code = CFM_NO_REACH;
                cmd_o.last = 1'b1;
                cmd_o.stop_timer = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              cmd_o.tick_dec = status_i.waiting;
              state_d = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ_NEXT: begin
        cmd_o.read_head = 1'b1;
        state_d = S_SEND_NEXT;
      end
      S_SEND_NEXT: begin
        if (status_i.out_free) begin
          cmd_o.emit = EMIT_SEND;
          cmd_o.last = 1'b1;
          cmd_o.start_timer = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    ready_d = (state_d == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ===== sv/stop_and_wait_tx_queue_top.sv =====
`timescale 1ns / 1ps
// Flow: S_IDLE accepts one transaction at a time, S_READ reads the ring head through the
// registered descriptor memory and S_DECIDE loads any first result into the output
// register; a matching success confirm that also resends the next entry reads the head
// again in S_READ_NEXT and loads it in S_SEND_NEXT. A stalled output holds the state.
// Reset: rst_ni clears the ring pointers, timer and handshake state at once; no clearing pass.
module stop_and_wait_tx_queue_top import sawtq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sawtq_in_if.sink              in_ch_i,
  sawtq_out_if.source           out_ch_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  desc_t      in_desc;
  res_t       res;
  logic       in_ready;
  logic       out_valid;

  always_comb begin
    in_desc.service_type   = in_ch_i.req_service_type;
    in_desc.packet_number  = in_ch_i.req_packet_number;
    in_desc.priority_lvl   = in_ch_i.req_priority;
    in_desc.dest_addr      = in_ch_i.req_dest_addr;
    in_desc.length         = in_ch_i.req_length;
    in_desc.payload_handle = in_ch_i.req_payload_handle;
  end

  sawtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sawtq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_kind_i       (in_ch_i.kind),
    .in_desc_i       (in_desc),
    .in_cfm_result_i (in_ch_i.cfm_result),
    .in_cfm_pn_i     (in_ch_i.cfm_packet_number),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ch_o.ready),
    .out_valid_o     (out_valid),
    .out_res_o       (res)
  );

  assign in_ch_i.ready               = in_ready;
  assign out_ch_o.valid              = out_valid;
  assign out_ch_o.out_kind           = res.out_kind;
  assign out_ch_o.target_node        = res.target_node;
  assign out_ch_o.out_dest_addr      = res.dest_addr;
  assign out_ch_o.out_priority       = res.priority_lvl;
  assign out_ch_o.out_service_type   = res.service_type;
  assign out_ch_o.out_packet_number  = res.packet_number;
  assign out_ch_o.out_length         = res.length;
  assign out_ch_o.out_payload_handle = res.payload_handle;
  assign out_ch_o.confirm_code       = res.confirm_code;
  assign out_ch_o.enqueue_failed     = res.enqueue_failed;
  assign out_ch_o.last               = res.last;

  // A request is written into the ring only when idle and there is room.
  a_enqueue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enqueue |-> (!status.full && !status.waiting))
    else $error("enqueue into a full ring or while waiting");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> status.count_nonzero)
    else $error("pop from an empty ring");

  // The output register is never overwritten before its transaction completes.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit != EMIT_NONE) |-> status.out_free)
    else $error("result emitted while output register is occupied");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ready) |=> !in_ready)
    else $error("new transaction accepted while one is in progress");

endmodule
